// File: rtl/core/pie_pkg.sv
// ----------------------------------------------------------------------------
// pie_pkg
// Shared types and constants of the particle impact erosion accumulator.
// ----------------------------------------------------------------------------
package pie_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PSI  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_K    = 2'd3;

  localparam logic OP_CLEAR = 1'b1;

  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] FLOW_RST     = 16'd1;
  localparam logic [15:0] PSI_RST      = 16'd512;
  localparam logic [15:0] K_RST        = 16'd512;
  // 10^6 = 2^6 * 15625, the power of two goes into the final shift
  localparam logic [31:0] MPA_ODD_PART = 32'd15625;
  // floor(y / 3) = (y * RECIP3) >> 33 for any 32-bit y
  localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;

  typedef enum logic [1:0] {
    JOB_CLEAR,
    JOB_RANGE,
    JOB_SKIP,
    JOB_IMPACT
  } job_kind_e;

  typedef struct packed {
    logic               op;
    logic [5:0]         patch_id;
    logic [11:0]        face_slot;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [31:0]        particle_count;
    logic [31:0]        particle_mass;
  } in_item_t;

  typedef struct packed {
    logic        counted;
    logic [63:0] face_erosion;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          wdata;
  } cfg_req_t;

  typedef struct packed {
    job_kind_e kind;
    in_item_t  item;
  } job_t;

  typedef struct packed {
    logic [15:0] flow;
    logic [15:0] psi;
    logic [15:0] k;
  } params_t;

endpackage

// File: rtl/core/pie_stream_if.sv
// ----------------------------------------------------------------------------
// pie_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface pie_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/pie_ram.sv
// ----------------------------------------------------------------------------
// pie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pie_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pie_front.sv
// ----------------------------------------------------------------------------
// pie_front
// Accepts events, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module pie_front #(
  parameter int FACE_SLOTS  = 4096,
  parameter int MAX_PATCHES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pie_stream_if.sink      in_i,
  input  logic [63:0]     mask_i,
  input  logic            hold_i,
  output pie_pkg::job_t   job_o,
  output logic            job_valid_o,
  input  logic            job_pop_i
);

  pie_pkg::job_t fifo_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          push, pop;
  logic          patch_ok;
  logic [31:0]   slot_ext;
  pie_pkg::job_t job_new;

  assign in_i.ready  = (cnt_q != 2'd2) && !hold_i;
  assign push        = in_i.valid && in_i.ready;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_pop_i;
  assign job_o       = fifo_q[rd_q];

  assign slot_ext = 32'(in_i.data.face_slot);
  assign patch_ok = (32'(in_i.data.patch_id) < 32'(MAX_PATCHES)) &&
                    mask_i[in_i.data.patch_id];

  always_comb begin
    job_new.item = in_i.data;
    priority if (in_i.data.op == pie_pkg::OP_CLEAR) begin
      job_new.kind = pie_pkg::JOB_CLEAR;
    end else if (slot_ext >= 32'(FACE_SLOTS)) begin
      job_new.kind = pie_pkg::JOB_RANGE;
    end else if (!patch_ok) begin
      job_new.kind = pie_pkg::JOB_SKIP;
    end else begin
      job_new.kind = pie_pkg::JOB_IMPACT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= job_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/core/pie_back.sv
// ----------------------------------------------------------------------------
// pie_back
// Erosion sequencer: shared multiplier, bit-serial square root and divider,
// limb-serial wide product, and the per-face erosion store.
// ----------------------------------------------------------------------------
module pie_back #(
  parameter int FACE_SLOTS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pie_pkg::job_t     job_i,
  input  logic              job_valid_i,
  output logic              job_pop_o,
  input  pie_pkg::params_t  par_i,
  output logic              init_busy_o,
  pie_stream_if.source      out_o
);

  localparam int AW = (FACE_SLOTS > 1) ? $clog2(FACE_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(FACE_SLOTS - 1);
  localparam logic [7:0]    SQRT_ITER = 8'd31;
  localparam logic [7:0]    DIV_SHORT = 8'd63;
  localparam logic [7:0]    DIV_LONG  = 8'd191;
  localparam logic [2:0]    LAST_LIMB = 3'd5;

  typedef enum logic [5:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_RDQ,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_CHK,
    ST_SQRT, ST_DIV, ST_LIMB,
    ST_S0, ST_S1, ST_S2, ST_S3, ST_C0, ST_C1,
    ST_H0, ST_H1, ST_P0, ST_P1, ST_P2, ST_P3, ST_F30,
    ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_B6,
    ST_WR, ST_OUT
  } state_e;

  state_e             state_q, nxt_q;
  pie_pkg::job_t      job_q;
  pie_pkg::out_item_t res_q, out_data_q;
  logic               out_valid_q;
  logic [AW-1:0]      sweep_q;
  logic [63:0]        q_q, m2_q;
  logic signed [49:0] dot_q;
  logic [30:0]        s_q, c_q, s2_q;
  logic [60:0]        ss_q;
  logic               shallow_q;
  logic [31:0]        t1_q, f24_q;
  logic [95:0]        p_q;
  logic [191:0]       a_q;
  logic [31:0]        rem_q, dv_q;
  logic [63:0]        sqx_q;
  logic [31:0]        sqr_q;
  logic [33:0]        sqrem_q;
  logic [7:0]         cnt_q;
  logic [2:0]         idx_q;
  logic [31:0]        carry_q, lv_q;
  logic               lsrc_p_q, ladd_q;
  logic signed [65:0] prod_q;

  logic [15:0]        p_eff, psi_eff, k_eff;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic [32:0]        div_sh, div_rem;
  logic               div_ge;
  logic [35:0]        sq_sh, sq_tr, sq_rem;
  logic               sq_ge;
  logic [7:0]         lidx;
  logic [191:0]       p_ext;
  logic [31:0]        a_limb, src_limb, add_limb;
  logic [63:0]        lt;
  logic [63:0]        f30, inc, new_val;
  logic [64:0]        sum;
  logic [30:0]        c2;
  logic [31:0]        slot_ext_j, slot_ext_q;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [63:0]        ram_wdata, ram_rdata;

  function automatic pie_pkg::out_item_t mk_res(logic counted, logic [63:0] v);
    pie_pkg::out_item_t r;
    r.counted      = counted;
    r.face_erosion = v;
    r.saturated    = (v == pie_pkg::ALL_ONES);
    return r;
  endfunction

  assign p_eff   = (par_i.flow == 16'd0) ? 16'd1 : par_i.flow;
  assign psi_eff = (par_i.psi == 16'd0) ? 16'd1 : par_i.psi;
  assign k_eff   = (par_i.k == 16'd0) ? 16'd1 : par_i.k;

  // bit-serial restoring divider
  assign div_sh  = {rem_q, a_q[191]};
  assign div_ge  = div_sh >= {1'b0, dv_q};
  assign div_rem = div_ge ? div_sh - {1'b0, dv_q} : div_sh;

  // digit-by-digit square root
  assign sq_sh  = {sqrem_q, sqx_q[63:62]};
  assign sq_tr  = {2'b00, sqr_q, 2'b01};
  assign sq_ge  = sq_sh >= sq_tr;
  assign sq_rem = sq_ge ? sq_sh - sq_tr : sq_sh;

  // limb-serial multiply-accumulate
  assign lidx     = {idx_q, 5'b00000};
  assign p_ext    = {96'd0, p_q};
  assign a_limb   = a_q[lidx +: 32];
  assign src_limb = lsrc_p_q ? p_ext[lidx +: 32] : a_limb;
  assign add_limb = ladd_q ? a_limb : 32'd0;
  assign lt       = prod[63:0] + 64'(add_limb) + 64'(carry_q);

  assign c2  = 31'h4000_0000 - s2_q;
  assign f30 = shallow_q ? ((64'(t1_q) > a_q[63:0]) ? 64'(t1_q) - a_q[63:0] : 64'd0)
                         : a_q[63:0];

  assign inc     = (|a_q[191:64]) ? pie_pkg::ALL_ONES : a_q[63:0];
  assign sum     = {1'b0, q_q} + {1'b0, inc};
  assign new_val = sum[64] ? pie_pkg::ALL_ONES : sum[63:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_M0:   begin mul_a = {job_q.item.vel_x[31], job_q.item.vel_x};
                     mul_b = {{17{job_q.item.normal_x[15]}}, job_q.item.normal_x}; end
      ST_M1:   begin mul_a = {job_q.item.vel_y[31], job_q.item.vel_y};
                     mul_b = {{17{job_q.item.normal_y[15]}}, job_q.item.normal_y}; end
      ST_M2:   begin mul_a = {job_q.item.vel_z[31], job_q.item.vel_z};
                     mul_b = {{17{job_q.item.normal_z[15]}}, job_q.item.normal_z}; end
      ST_M3:   begin mul_a = {job_q.item.vel_x[31], job_q.item.vel_x}; mul_b = mul_a; end
      ST_M4:   begin mul_a = {job_q.item.vel_y[31], job_q.item.vel_y}; mul_b = mul_a; end
      ST_M5:   begin mul_a = {job_q.item.vel_z[31], job_q.item.vel_z}; mul_b = mul_a; end
      ST_S2:   begin mul_a = {2'b00, s_q}; mul_b = {2'b00, s_q}; end
      ST_C0:   begin mul_a = {17'd0, k_eff}; mul_b = {1'b0, sqr_q}; end
      ST_H0:   begin mul_a = {2'b00, s_q}; mul_b = {2'b00, c_q}; end
      ST_P0:   begin mul_a = {17'd0, k_eff}; mul_b = {2'b00, c2}; end
      ST_P2:   begin mul_a = {1'b0, t1_q}; mul_b = {1'b0, pie_pkg::RECIP3}; end
      ST_LIMB: begin mul_a = {1'b0, src_limb}; mul_b = {1'b0, lv_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign slot_ext_j = 32'(job_i.item.face_slot);
  assign slot_ext_q = 32'(job_q.item.face_slot);

  assign ram_we    = (state_q == ST_INIT) || (state_q == ST_CLR) || (state_q == ST_WR);
  assign ram_waddr = (state_q == ST_WR) ? slot_ext_q[AW-1:0] : sweep_q;
  assign ram_wdata = (state_q == ST_WR) ? new_val : 64'd0;
  assign ram_re    = (state_q == ST_IDLE) && job_valid_i;
  assign ram_raddr = slot_ext_j[AW-1:0];

  pie_ram #(
    .WIDTH (64),
    .DEPTH (FACE_SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign job_pop_o   = (state_q == ST_IDLE);
  assign init_busy_o = (state_q == ST_INIT);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      nxt_q       <= ST_IDLE;
      job_q       <= '0;
      res_q       <= '0;
      out_data_q  <= '0;
      out_valid_q <= 1'b0;
      sweep_q     <= '0;
      q_q         <= '0;
      m2_q        <= '0;
      dot_q       <= '0;
      s_q         <= '0;
      c_q         <= '0;
      s2_q        <= '0;
      ss_q        <= '0;
      shallow_q   <= 1'b0;
      t1_q        <= '0;
      f24_q       <= '0;
      p_q         <= '0;
      a_q         <= '0;
      rem_q       <= '0;
      dv_q        <= '0;
      sqx_q       <= '0;
      sqr_q       <= '0;
      sqrem_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      carry_q     <= '0;
      lv_q        <= '0;
      lsrc_p_q    <= 1'b0;
      ladd_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_q == LAST_SLOT) begin
            sweep_q <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q <= job_i;
            unique case (job_i.kind)
              pie_pkg::JOB_CLEAR: begin
                sweep_q <= '0;
                state_q <= ST_CLR;
              end
              pie_pkg::JOB_RANGE: begin
                res_q   <= mk_res(1'b0, 64'd0);
                state_q <= ST_OUT;
              end
              default: state_q <= ST_RDQ;
            endcase
          end
        end
        ST_CLR: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_q == LAST_SLOT) begin
            sweep_q <= '0;
            res_q   <= mk_res(1'b0, 64'd0);
            state_q <= ST_OUT;
          end
        end
        ST_RDQ: begin
          q_q <= ram_rdata;
          if (job_q.kind == pie_pkg::JOB_SKIP) begin
            res_q   <= mk_res(1'b0, ram_rdata);
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_M0;
          end
        end
        ST_M0: state_q <= ST_M1;
        ST_M1: begin
          dot_q   <= prod_q[49:0];
          state_q <= ST_M2;
        end
        ST_M2: begin
          dot_q   <= dot_q + prod_q[49:0];
          state_q <= ST_M3;
        end
        ST_M3: begin
          dot_q   <= dot_q + prod_q[49:0];
          state_q <= ST_M4;
        end
        ST_M4: begin
          m2_q    <= prod_q[63:0];
          state_q <= ST_M5;
        end
        ST_M5: begin
          m2_q    <= m2_q + prod_q[63:0];
          state_q <= ST_M6;
        end
        ST_M6: begin
          m2_q    <= m2_q + prod_q[63:0];
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (dot_q[49] || (m2_q == 64'd0)) begin
            res_q   <= mk_res(1'b0, q_q);
            state_q <= ST_OUT;
          end else begin
            sqx_q   <= m2_q;
            sqr_q   <= '0;
            sqrem_q <= '0;
            cnt_q   <= SQRT_ITER;
            nxt_q   <= ST_S0;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          sqx_q   <= {sqx_q[61:0], 2'b00};
          sqr_q   <= {sqr_q[30:0], sq_ge};
          sqrem_q <= sq_rem[33:0];
          if (cnt_q == 8'd0) begin
            state_q <= nxt_q;
          end else begin
            cnt_q <= cnt_q - 8'd1;
          end
        end
        ST_DIV: begin
          a_q   <= {a_q[190:0], div_ge};
          rem_q <= div_rem[31:0];
          if (cnt_q == 8'd0) begin
            state_q <= nxt_q;
          end else begin
            cnt_q <= cnt_q - 8'd1;
          end
        end
        ST_LIMB: begin
          a_q[lidx +: 32] <= lt[31:0];
          carry_q         <= lt[63:32];
          if (idx_q == LAST_LIMB) begin
            idx_q   <= '0;
            state_q <= nxt_q;
          end else begin
            idx_q <= idx_q + 3'd1;
          end
        end
        ST_S0: begin
          a_q     <= {dot_q[47:0], 16'd0, 128'd0};
          rem_q   <= '0;
          dv_q    <= sqr_q;
          cnt_q   <= DIV_SHORT;
          nxt_q   <= ST_S1;
          state_q <= ST_DIV;
        end
        ST_S1: begin
          s_q     <= (a_q[63:0] > 64'h4000_0000) ? 31'h4000_0000 : a_q[30:0];
          state_q <= ST_S2;
        end
        ST_S2: state_q <= ST_S3;
        ST_S3: begin
          ss_q    <= prod_q[60:0];
          sqx_q   <= 64'h1000_0000_0000_0000 - 64'(prod_q[60:0]);
          sqr_q   <= '0;
          sqrem_q <= '0;
          cnt_q   <= SQRT_ITER;
          nxt_q   <= ST_C0;
          state_q <= ST_SQRT;
        end
        ST_C0: begin
          c_q     <= sqr_q[30:0];
          s2_q    <= ss_q[60:30];
          state_q <= ST_C1;
        end
        ST_C1: begin
          shallow_q <= (47'({s_q, 10'd0}) + 47'({s_q, 9'd0})) < prod_q[46:0];
          if ((47'({s_q, 10'd0}) + 47'({s_q, 9'd0})) < prod_q[46:0]) begin
            state_q <= ST_H0;
          end else begin
            state_q <= ST_P0;
          end
        end
        ST_H0: state_q <= ST_H1;
        ST_H1: begin
          t1_q    <= prod_q[60:29];
          a_q     <= {64'({s2_q, 10'd0}) + 64'({s2_q, 9'd0}), 128'd0};
          rem_q   <= '0;
          dv_q    <= 32'(k_eff);
          cnt_q   <= DIV_SHORT;
          nxt_q   <= ST_F30;
          state_q <= ST_DIV;
        end
        ST_P0: state_q <= ST_P1;
        // steep: f24 = floor((k * c2 >> 15) / 3), kept pre-shifted as f30
        ST_P1: begin
          t1_q    <= prod_q[46:15];
          state_q <= ST_P2;
        end
        ST_P2: state_q <= ST_P3;
        ST_P3: begin
          a_q     <= {128'd0, 26'd0, prod_q[64:33], 6'd0};
          state_q <= ST_F30;
        end
        ST_F30: begin
          f24_q    <= f30[37:6];
          a_q      <= 192'(job_q.item.particle_count);
          idx_q    <= '0;
          carry_q  <= '0;
          lv_q     <= job_q.item.particle_mass;
          lsrc_p_q <= 1'b0;
          ladd_q   <= 1'b0;
          nxt_q    <= ST_B1;
          state_q  <= ST_LIMB;
        end
        ST_B1: begin
          carry_q <= '0;
          lv_q    <= f24_q;
          nxt_q   <= ST_B2;
          state_q <= ST_LIMB;
        end
        ST_B2: begin
          p_q     <= a_q[95:0];
          carry_q <= '0;
          lv_q    <= m2_q[63:32];
          nxt_q   <= ST_B3;
          state_q <= ST_LIMB;
        end
        ST_B3: begin
          a_q      <= {a_q[159:0], 32'd0};
          carry_q  <= '0;
          lv_q     <= m2_q[31:0];
          lsrc_p_q <= 1'b1;
          ladd_q   <= 1'b1;
          nxt_q    <= ST_B4;
          state_q  <= ST_LIMB;
        end
        // 256 * 10^6 * p = 2^14 * (15625 * p)
        ST_B4: begin
          a_q     <= {14'd0, a_q[191:14]};
          rem_q   <= '0;
          dv_q    <= 32'(p_eff) * pie_pkg::MPA_ODD_PART;
          cnt_q   <= DIV_LONG;
          nxt_q   <= ST_B5;
          state_q <= ST_DIV;
        end
        ST_B5: begin
          rem_q   <= '0;
          dv_q    <= 32'(psi_eff);
          cnt_q   <= DIV_LONG;
          nxt_q   <= ST_B6;
          state_q <= ST_DIV;
        end
        ST_B6: begin
          rem_q   <= '0;
          dv_q    <= 32'(k_eff);
          cnt_q   <= DIV_LONG;
          nxt_q   <= ST_WR;
          state_q <= ST_DIV;
        end
        ST_WR: begin
          res_q   <= mk_res(1'b1, new_val);
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/particle_impact_erosion_accumulator_top.sv
// ----------------------------------------------------------------------------
// particle_impact_erosion_accumulator_top
// Finnie erosion accumulator over a per-face store, with config registers.
// Impact events go through the bit-serial divider (three 192-step passes for the
//   final scaling) and two 32-step square roots.
// Out-of-range or unlisted events and those moving away or at rest take a short
//   path; clear sweeps every face slot. A two-entry queue takes new events meanwhile.
// Reset: a clearing pass zeroes the store, no events taken.
// ----------------------------------------------------------------------------
module particle_impact_erosion_accumulator_top #(
  parameter int FACE_SLOTS  = 4096,
  parameter int MAX_PATCHES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pie_stream_if.sink   in_i,
  pie_stream_if.source out_o,
  pie_stream_if.sink   cfg_i
);

  logic [63:0]      mask_q;
  pie_pkg::params_t par_q;
  pie_pkg::job_t    job;
  logic             job_valid, job_pop, init_busy;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      par_q.flow <= pie_pkg::FLOW_RST;
      par_q.psi  <= pie_pkg::PSI_RST;
      par_q.k    <= pie_pkg::K_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.idx)
        pie_pkg::CFG_MASK: mask_q     <= cfg_i.data.wdata;
        pie_pkg::CFG_FLOW: par_q.flow <= cfg_i.data.wdata[15:0];
        pie_pkg::CFG_PSI:  par_q.psi  <= cfg_i.data.wdata[15:0];
        pie_pkg::CFG_K:    par_q.k    <= cfg_i.data.wdata[15:0];
        default:           mask_q     <= mask_q;
      endcase
    end
  end

  pie_front #(
    .FACE_SLOTS  (FACE_SLOTS),
    .MAX_PATCHES (MAX_PATCHES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mask_i      (mask_q),
    .hold_i      (init_busy),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_pop_i   (job_pop)
  );

  pie_back #(
    .FACE_SLOTS (FACE_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .par_i       (par_q),
    .init_busy_o (init_busy),
    .out_o       (out_o)
  );

endmodule

// File: dv/pie_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pie_checker
// Watches the event, result and register channels of the erosion
// accumulator, keeps its own copy of the registers and the per-face store,
// works out the Finnie erosion result of each accepted event and compares
// it field by field with the results in order.
// ----------------------------------------------------------------------------
module pie_checker
  import pie_pkg::*;
#(
  parameter int FACE_SLOTS = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  cfg_req_t  cfg_data_i,
  output int        pending_o,
  output int        errors_o
);

  logic [63:0] enable_mask;
  logic [15:0] flow_reg, psi_reg, k_reg;
  logic [63:0] erosion_mem [FACE_SLOTS];
  out_item_t   erosion_due [$];

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_item_t apply_impact(in_item_t it);
    out_item_t r;
    longint vx, vy, vz, nx, ny, nz, sdot;
    logic [63:0] mag2, magu, dot, s, c, s2, c2, f30, t1, t2, q, inc, pp, ps, kk;
    logic [191:0] num, den, quo;
    r = '0;
    if (it.op == OP_CLEAR) begin
      foreach (erosion_mem[i]) erosion_mem[i] = '0;
      return r;
    end
    if (int'(it.face_slot) >= FACE_SLOTS) return r;
    q = erosion_mem[it.face_slot];
    r.face_erosion = q;
    r.saturated = (q == ALL_ONES);
    if (!enable_mask[it.patch_id]) return r;
    vx = it.vel_x; vy = it.vel_y; vz = it.vel_z;
    nx = it.normal_x; ny = it.normal_y; nz = it.normal_z;
    sdot = vx * nx + vy * ny + vz * nz;
    if (sdot < 0) return r;
    mag2 = 64'(vx * vx) + 64'(vy * vy) + 64'(vz * vz);
    if (mag2 == 0) return r;
    pp = (flow_reg == 0) ? 64'd1 : 64'(flow_reg);
    ps = (psi_reg == 0) ? 64'd1 : 64'(psi_reg);
    kk = (k_reg == 0) ? 64'd1 : 64'(k_reg);
    magu = root_floor(mag2);
    dot = 64'(sdot);
    s = (dot << 16) / magu;
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    c = root_floor((64'd1 << 60) - s * s);
    s2 = (s * s) >> 30;
    c2 = (64'd1 << 30) - s2;
    if (6 * s * 256 < kk * c) begin
      t1 = (2 * s * c) >> 30;
      t2 = (1536 * s2) / kk;
      f30 = (t1 > t2) ? t1 - t2 : 64'd0;
    end else begin
      f30 = (kk * c2) / 1536;
    end
    num = 192'(it.particle_count);
    num = num * 192'(it.particle_mass);
    num = num * 192'(mag2);
    num = num * 192'(f30 >> 6);
    den = 192'd256 * 192'(pp);
    den = den * 192'd1000000;
    den = den * 192'(ps);
    den = den * 192'(kk);
    quo = num / den;
    inc = (quo[191:64] != 0) ? ALL_ONES : quo[63:0];
    q = (ALL_ONES - q < inc) ? ALL_ONES : q + inc;
    erosion_mem[it.face_slot] = q;
    r.counted = 1'b1;
    r.face_erosion = q;
    r.saturated = (q == ALL_ONES);
    return r;
  endfunction

  assign pending_o = erosion_due.size();

  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      enable_mask = '0;
      flow_reg = FLOW_RST;
      psi_reg = PSI_RST;
      k_reg = K_RST;
      foreach (erosion_mem[i]) erosion_mem[i] = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.idx)
          CFG_MASK: enable_mask = cfg_data_i.wdata;
          CFG_FLOW: flow_reg = cfg_data_i.wdata[15:0];
          CFG_PSI:  psi_reg = cfg_data_i.wdata[15:0];
          CFG_K:    k_reg = cfg_data_i.wdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (erosion_due.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, out_data_i);
          errors_o++;
        end else begin
          exp_r = erosion_due.pop_front();
          if (exp_r.counted !== out_data_i.counted) begin
            $display("%0t: counted expected %0b actual %0b", $time,
                     exp_r.counted, out_data_i.counted);
            errors_o++;
          end
          if (exp_r.face_erosion !== out_data_i.face_erosion) begin
            $display("%0t: face_erosion expected %0h actual %0h", $time,
                     exp_r.face_erosion, out_data_i.face_erosion);
            errors_o++;
          end
          if (exp_r.saturated !== out_data_i.saturated) begin
            $display("%0t: saturated expected %0b actual %0b", $time,
                     exp_r.saturated, out_data_i.saturated);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) erosion_due.push_back(apply_impact(in_data_i));
    end
  end

endmodule

// File: dv/particle_impact_erosion_accumulator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_impact_erosion_accumulator_top_tb
// Drives impact and clear events through the erosion accumulator under
// several register settings, with bursty input, receiver stalls and a long
// output hold-off; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module particle_impact_erosion_accumulator_top_tb;
  import pie_pkg::*;

  localparam int WATCHDOG = 40000;
  localparam int PHASE_ITEMS = 116;

  logic clk, rst_n;
  int   errors, pending, idle_cycles, burst_left;
  bit   hold_req;

  pie_stream_if #(.T(in_item_t))  in_if ();
  pie_stream_if #(.T(out_item_t)) out_if ();
  pie_stream_if #(.T(cfg_req_t))  cfg_if ();

  particle_impact_erosion_accumulator_top DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  pie_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_if.valid),
    .in_ready_i (in_if.ready),
    .in_data_i  (in_if.data),
    .out_valid_i(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_data_i (out_if.data),
    .cfg_valid_i(cfg_if.valid),
    .cfg_ready_i(cfg_if.ready),
    .cfg_data_i (cfg_if.data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall modes, plus one long hold-off on request
  initial begin
    int  mode_left;
    bit  stall_on;
    mode_left = 100;
    stall_on = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_if.ready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
        @(posedge clk);
        mode_left--;
        if (mode_left == 0) begin
          stall_on = $urandom_range(0, 1);
          mode_left = $urandom_range(20, 300);
        end
      end
    end
  end

  task automatic send_event(in_item_t it);
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{idx: idx, wdata: val};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_regs(logic [63:0] mask, logic [15:0] flow, logic [15:0] psi,
                          logic [15:0] k);
    write_reg(CFG_MASK, mask);
    write_reg(CFG_FLOW, 64'(flow));
    write_reg(CFG_PSI, 64'(psi));
    write_reg(CFG_K, 64'(k));
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t impact(logic [5:0] patch, logic [11:0] slot,
                                      logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                      logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                      logic [31:0] cnt, logic [31:0] mass);
    in_item_t it;
    it = '{op: 1'b0, patch_id: patch, face_slot: slot, vel_x: vx, vel_y: vy,
           vel_z: vz, normal_x: nx, normal_y: ny, normal_z: nz,
           particle_count: cnt, particle_mass: mass};
    return it;
  endfunction

  function automatic in_item_t random_event();
    in_item_t it;
    longint   d;
    int       axis;
    it = '0;
    if ($urandom_range(0, 99) == 0) begin
      it.op = OP_CLEAR;
      it.patch_id = $urandom;
      it.face_slot = $urandom;
      return it;
    end
    it.patch_id = $urandom;
    it.face_slot = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
    it.vel_x = $signed($urandom) >>> $urandom_range(0, 31);
    it.vel_y = $signed($urandom) >>> $urandom_range(0, 31);
    it.vel_z = $signed($urandom) >>> $urandom_range(0, 31);
    if ($urandom_range(0, 39) == 0) begin
      it.vel_x = '0; it.vel_y = '0; it.vel_z = '0;
    end
    if ($urandom_range(0, 4) == 0) begin
      it.normal_x = 16'($signed($urandom_range(0, 32768)) - 16384);
      it.normal_y = 16'($signed($urandom_range(0, 32768)) - 16384);
      it.normal_z = 16'($signed($urandom_range(0, 32768)) - 16384);
    end else begin
      axis = $urandom_range(0, 2);
      it.normal_x = (axis == 0) ? 16'sd16384 : 16'sd0;
      it.normal_y = (axis == 1) ? 16'sd16384 : 16'sd0;
      it.normal_z = (axis == 2) ? 16'sd16384 : 16'sd0;
    end
    d = longint'(it.vel_x) * it.normal_x + longint'(it.vel_y) * it.normal_y +
        longint'(it.vel_z) * it.normal_z;
    if (d < 0 && $urandom_range(0, 9) != 0) begin
      it.normal_x = -it.normal_x; it.normal_y = -it.normal_y; it.normal_z = -it.normal_z;
    end
    it.particle_count = $urandom >> $urandom_range(0, 31);
    it.particle_mass = $urandom >> $urandom_range(0, 31);
    return it;
  endfunction

  initial begin
    in_item_t clr;
    hold_req = 1'b0;
    idle_cycles = 0;
    burst_left = 4;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, special cases, zero flow stress used as one
    set_regs(64'h7FFF_FFFF_FFFF_FFFF, 16'd0, 16'd1, 16'd1);
    clr = '0;
    clr.op = OP_CLEAR;
    send_event(impact(6'd0, 12'd0, 32'h0001_0000, 0, 0, 16'sd16384, 0, 0, 1, 1));
    send_event(impact(6'd0, 12'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      -16'sd16384, -16'sd16384, -16'sd16384, '1, '1));
    send_event(impact(6'd1, 12'd0, 32'h0001_0000, 0, 0, 16'sd16384, 0, 0, 5, 5));
    send_event(impact(6'd62, 12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      16'sd16384, 16'sd16384, 16'sd16384, 32'd1000, 32'd1000));
    send_event(impact(6'd63, 12'd4095, 32'h0001_0000, 0, 0, 16'sd16384, 0, 0, 9, 9));
    send_event(impact(6'd2, 12'd7, 32'h0001_0000, 32'h0010_0000, 0,
                      16'sd16384, 0, 0, 32'd100, 32'd100));
    send_event(impact(6'd2, 12'd7, 32'hFFFF_0000, 0, 0, 16'sd16384, 0, 0, 3, 3));
    send_event(impact(6'd2, 12'd7, 0, 0, 0, 16'sd16384, 0, 0, 3, 3));
    send_event(impact(6'd2, 12'd7, 32'h0005_0000, 32'h0005_0000, 0,
                      0, 16'sd16384, 0, 0, '1));
    send_event(impact(6'd3, 12'd8, 32'h0100_0000, 32'h0000_0001, 0,
                      16'sd16384, 0, 0, '1, 32'd77));
    send_event(impact(6'd3, 12'd8, 0, 32'h0002_0000, 0, 0, 16'sd16384, 0, 32'd4, 32'd4));
    send_event(impact(6'd4, 12'd9, 32'h0002_0000, 32'h0020_0000, 32'h0001_0000,
                      16'sd16384, 0, 0, '1, '1));
    send_event(clr);
    send_event(impact(6'd0, 12'd0, 32'h0001_0000, 0, 0, 16'sd16384, 0, 0, 1, 1));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_regs('1, 16'd65535, 16'd65535, 16'd65535);
        1: set_regs({$urandom, $urandom}, 16'd1, 16'd512, 16'd512);
        2: set_regs('1, 16'($urandom), 16'($urandom_range(1, 65535)), 16'd1);
        3: set_regs(64'h5555_AAAA_0F0F_F0F0, 16'd0, 16'd0, 16'd0);
        default: set_regs({$urandom, $urandom}, 16'($urandom), 16'($urandom),
                          16'($urandom));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 20) hold_req = 1'b1;
        if (ph == 2 && n == 50) drain();
        send_event(random_event());
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
